@@ rtl/shda_pkg.sv @@
// Shared types, constants and helper functions for the spatial hash density accumulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package shda_pkg;

    // Table geometry. TABLE_ENTRIES must be a power of two.
    localparam int TABLE_ENTRIES = 1024;
    localparam int PROBE_LIMIT   = 8;
    localparam int KEY_BITS      = 24;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PROBE_W       = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    // Field widths.
    localparam int POS_W     = 32;
    localparam int PWR_W     = 32;
    localparam int INV_W     = 32;
    localparam int SCALE_W   = 48;
    localparam int SUM_W     = 48;
    localparam int TALLY_W   = 32;
    localparam int OCC_W     = 11;
    localparam int TOTAL_W   = 48;
    localparam int HASH_W    = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 240;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [OCC_W-1:0]   OCC_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [INV_W-1:0]   INV_RESET = 32'h0001_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IRR_SCALE     = 1'b1;

    // Command codes.
    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_HASH,
        S_READ,
        S_CMP,
        S_MUL,
        S_WRITE,
        S_OUT
    } state_t;

    // One table entry as stored in memory.
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key_x;
        logic [KEY_BITS-1:0] key_y;
        logic [KEY_BITS-1:0] key_z;
        logic [SUM_W-1:0]    sum_r;
        logic [SUM_W-1:0]    sum_g;
        logic [SUM_W-1:0]    sum_b;
        logic [TALLY_W-1:0]  tally;
    } entry_t;

    // Access request from the controller to the table memory.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } tbl_req_t;

    // Multiplier constant of the hash for each axis.
    function automatic logic [HASH_W-1:0] hash_const(input logic [1:0] axis);
        logic [HASH_W-1:0] c;
        case (axis)
            2'd0:    c = 32'h9E37_79B1;
            2'd1:    c = 32'h85EB_CA77;
            2'd2:    c = 32'hC2B2_AE3D;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/spatial_hash_density_accumulator.sv @@
// Top level of the spatial hash density accumulator: controller, key and hash units.
// Depends on shda_pkg, shda_table and shda_scale.
//
// Usage:
// The s_ channel takes one request: tuser is the command (deposit or lookup),
// tdata the position and RGB power. The m_ channel returns exactly one result
// per request: tuser is the status, tdata the irradiance, cell photon count,
// occupied-cell total and deposit total.
// Configuration (cell size reciprocal, irradiance scale) is to be written through
// cfg_wr_en / cfg_index / cfg_wdata only while the block is idle; the block does
// not enforce this. Sequence: an accept, key multiplies and then hash multiplies
// for the three axes, then a read and a compare per probed slot (1 to 8 probes)
// on the single table read port, then a write for a deposit that is not dropped
// or, for a found lookup, the 12 steps of the shared scaling multiplier and its
// done flag, then the load of the output register. One request is in flight at
// a time. After reset the table is cleared one slot per cycle, and no request
// is accepted meanwhile. The output register holds a result while the receiver
// stalls; the next request is accepted and processed meanwhile and waits in
// the controller until the output register frees up.
`default_nettype none

module spatial_hash_density_accumulator (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Request channel.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // tdata: pos_x, pos_y, pos_z, power_r, power_g, power_b (32 bits each).
    input  wire [shda_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: command.
    input  wire                              s_tuser,
    // Result channel.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // tdata: irradiance_r, irradiance_g, irradiance_b (48 each), cell_photons (32),
    // occupied_cells (11), total_deposits (48), 5 zero bits.
    output logic [shda_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: status.
    output logic [1:0]                       m_tuser,
    // Configuration write port.
    input  wire                              cfg_wr_en,
    input  wire [shda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [shda_pkg::CFG_W-1:0]        cfg_wdata
);
    import shda_pkg::*;

    state_t               state_reg, state_next;
    logic [INV_W-1:0]     inv_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic                 cmd_reg;
    logic [POS_W-1:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [PWR_W-1:0]     pwr_r_reg, pwr_g_reg, pwr_b_reg;
    logic [1:0]           step_reg;
    logic [KEY_BITS-1:0]  kx_reg, ky_reg, kz_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [PROBE_W-1:0]   probe_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [SUM_W-1:0]     sum_r_reg, sum_g_reg, sum_b_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic                 new_reg;
    status_t              status_reg;
    logic [TALLY_W-1:0]   photons_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    tbl_req_t             tbl_req;
    entry_t               rd_entry;
    logic                 clear_busy;
    logic                 mul_start;
    logic                 mul_done;
    logic [SUM_W-1:0]     irr_r, irr_g, irr_b;

    logic                 in_accept;
    logic                 out_free;
    logic [POS_W-1:0]     pos_sel;
    logic signed [64:0]   key_prod;
    logic [KEY_BITS-1:0]  key_new;
    logic [KEY_BITS-1:0]  key_sel;
    logic [KEY_BITS+HASH_W-1:0] hash_prod;
    logic [HASH_W-1:0]    hash_next;
    logic                 key_match;
    logic                 last_probe;
    logic [SUM_W:0]       add_r, add_g, add_b;
    logic [SUM_W-1:0]     new_r, new_g, new_b;
    logic [TALLY_W-1:0]   tally_new;
    logic [SUM_W-1:0]     out_ir, out_ig, out_ib;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Key and hash datapath: one multiplier of each kind, one axis per cycle.
    always_comb begin
        case (step_reg)
            2'd0:    pos_sel = pos_x_reg;
            2'd1:    pos_sel = pos_y_reg;
            default: pos_sel = pos_z_reg;
        endcase
        key_prod = $signed({pos_sel[POS_W-1], pos_sel}) * $signed({1'b0, inv_reg});
        key_new  = key_prod[32 +: KEY_BITS];
        case (step_reg)
            2'd0:    key_sel = kx_reg;
            2'd1:    key_sel = ky_reg;
            default: key_sel = kz_reg;
        endcase
        hash_prod = key_sel * hash_const(step_reg);
        hash_next = ((step_reg == 2'd0) ? '0 : hash_reg) ^ hash_prod[HASH_W-1:0];
    end

    // Probe compare and deposit arithmetic.
    always_comb begin
        key_match  = (rd_entry.key_x == kx_reg) && (rd_entry.key_y == ky_reg) &&
                     (rd_entry.key_z == kz_reg);
        last_probe = (probe_reg == PROBE_W'(PROBE_LIMIT - 1));
        add_r      = {1'b0, sum_r_reg} + (SUM_W + 1)'(pwr_r_reg);
        add_g      = {1'b0, sum_g_reg} + (SUM_W + 1)'(pwr_g_reg);
        add_b      = {1'b0, sum_b_reg} + (SUM_W + 1)'(pwr_b_reg);
        new_r      = add_r[SUM_W] ? SUM_MAX : add_r[SUM_W-1:0];
        new_g      = add_g[SUM_W] ? SUM_MAX : add_g[SUM_W-1:0];
        new_b      = add_b[SUM_W] ? SUM_MAX : add_b[SUM_W-1:0];
        tally_new  = (tally_reg == TALLY_MAX) ? tally_reg : tally_reg + 1'b1;
    end

    // Next state and table requests.
    always_comb begin
        state_next      = state_reg;
        mul_start       = 1'b0;
        tbl_req         = '0;
        tbl_req.rd_addr = hash_reg[IDX_W-1:0] + IDX_W'(probe_reg);
        tbl_req.wr_addr = slot_reg;
        tbl_req.wr_data = '{valid: 1'b1, key_x: kx_reg, key_y: ky_reg, key_z: kz_reg,
                            sum_r: new_r, sum_g: new_g, sum_b: new_b, tally: tally_new};
        s_tready        = (state_reg == S_IDLE) && !clear_busy;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) state_next = S_KEY;
            end
            S_KEY: begin
                if (step_reg == 2'd2) state_next = S_HASH;
            end
            S_HASH: begin
                if (step_reg == 2'd2) state_next = S_READ;
            end
            S_READ: begin
                tbl_req.rd_en = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP: begin
                if (rd_entry.valid && !key_match) begin
                    state_next = last_probe ? S_OUT : S_READ;
                    if (last_probe && cmd_reg == CMD_LOOKUP) state_next = S_OUT;
                end else if (cmd_reg == CMD_LOOKUP) begin
                    if (rd_entry.valid) begin
                        state_next = S_MUL;
                        mul_start  = 1'b1;
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_MUL: begin
                if (mul_done) state_next = S_OUT;
            end
            S_WRITE: begin
                tbl_req.wr_en = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg   <= INV_RESET;
            scale_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INV_CELL_SIZE: inv_reg   <= cfg_wdata[INV_W-1:0];
                REG_IRR_SCALE:     scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture, key and hash steps, probe bookkeeping.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg   <= s_tuser;
            pos_x_reg <= s_tdata[31:0];
            pos_y_reg <= s_tdata[63:32];
            pos_z_reg <= s_tdata[95:64];
            pwr_r_reg <= s_tdata[127:96];
            pwr_g_reg <= s_tdata[159:128];
            pwr_b_reg <= s_tdata[191:160];
        end
        case (state_reg)
            S_IDLE: begin
                step_reg <= '0;
            end
            S_KEY: begin
                case (step_reg)
                    2'd0:    kx_reg <= key_new;
                    2'd1:    ky_reg <= key_new;
                    default: kz_reg <= key_new;
                endcase
                step_reg <= (step_reg == 2'd2) ? 2'd0 : step_reg + 1'b1;
            end
            S_HASH: begin
                hash_reg  <= hash_next;
                step_reg  <= step_reg + 1'b1;
                probe_reg <= '0;
            end
            S_READ: begin
                slot_reg <= tbl_req.rd_addr;
            end
            S_CMP: begin
                probe_reg   <= probe_reg + 1'b1;
                new_reg     <= !rd_entry.valid;
                sum_r_reg   <= rd_entry.valid ? rd_entry.sum_r : '0;
                sum_g_reg   <= rd_entry.valid ? rd_entry.sum_g : '0;
                sum_b_reg   <= rd_entry.valid ? rd_entry.sum_b : '0;
                tally_reg   <= rd_entry.valid ? rd_entry.tally : '0;
                photons_reg <= '0;
                if (rd_entry.valid && !key_match) begin
                    status_reg <= (cmd_reg == CMD_LOOKUP) ? ST_ABSENT : ST_DROPPED;
                end else if (cmd_reg == CMD_LOOKUP && !rd_entry.valid) begin
                    status_reg <= ST_ABSENT;
                end else begin
                    status_reg <= ST_OK;
                    if (cmd_reg == CMD_LOOKUP) photons_reg <= rd_entry.tally;
                end
            end
            S_WRITE: begin
                photons_reg <= tally_new;
            end
            default: ;
        endcase
    end

    // Running totals.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            total_reg <= '0;
        end else if (state_reg == S_WRITE) begin
            if (new_reg && occ_reg != OCC_MAX) occ_reg <= occ_reg + 1'b1;
            if (total_reg != TOTAL_MAX) total_reg <= total_reg + 1'b1;
        end
    end

    // Output register.
    assign out_ib = (cmd_reg == CMD_LOOKUP && status_reg == ST_OK) ? irr_b : '0;
    assign out_ig = (cmd_reg == CMD_LOOKUP && status_reg == ST_OK) ? irr_g : '0;
    assign out_ir = (cmd_reg == CMD_LOOKUP && status_reg == ST_OK) ? irr_r : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {5'b0, total_reg, occ_reg, photons_reg, out_ib, out_ig, out_ir};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    shda_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (tbl_req),
        .rd_data    (rd_entry),
        .clear_busy (clear_busy)
    );

    shda_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .sum_r   (sum_r_reg),
        .sum_g   (sum_g_reg),
        .sum_b   (sum_b_reg),
        .scale   (scale_reg),
        .done    (mul_done),
        .irr_r   (irr_r),
        .irr_g   (irr_g),
        .irr_b   (irr_b)
    );

endmodule

`default_nettype wire

@@ rtl/shda_table.sv @@
// Cell table memory: one synchronous RAM holding key, sums and tally per slot.
// Depends on shda_pkg. Runs a clearing pass over every slot after reset.
`default_nettype none

module shda_table (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire shda_pkg::tbl_req_t   req,
    output shda_pkg::entry_t          rd_data,
    output logic                      clear_busy
);
    import shda_pkg::*;

    entry_t           mem [TABLE_ENTRIES];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic             clear_busy_reg;

    // Clearing pass: one slot per cycle after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end else if (clear_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

endmodule

`default_nettype wire

@@ rtl/shda_scale.sv @@
// Iterative irradiance scaler: (sum * scale + 2^31) >> 32, saturated, for three channels.
// Depends on shda_pkg. One 24x24 partial product per cycle.
`default_nettype none

module shda_scale (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire [shda_pkg::SUM_W-1:0]   sum_r,
    input  wire [shda_pkg::SUM_W-1:0]   sum_g,
    input  wire [shda_pkg::SUM_W-1:0]   sum_b,
    input  wire [shda_pkg::SCALE_W-1:0] scale,
    output logic                        done,
    output logic [shda_pkg::SUM_W-1:0]  irr_r,
    output logic [shda_pkg::SUM_W-1:0]  irr_g,
    output logic [shda_pkg::SUM_W-1:0]  irr_b
);
    import shda_pkg::*;

    localparam int HALF_W = 24;
    localparam int ACC_W  = 96;

    logic [3:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [SUM_W-1:0]   irr_r_reg, irr_g_reg, irr_b_reg;
    logic [SUM_W-1:0]   res_next;
    logic [1:0]         chan;
    logic [1:0]         part;
    logic [SUM_W-1:0]   a_sel;
    logic [HALF_W-1:0]  a_half, b_half;
    logic [2*HALF_W-1:0] pp;
    logic [ACC_W-1:0]   pp_shifted;
    logic [ACC_W-1:0]   acc_base;

    assign chan = step_reg[3:2];
    assign part = step_reg[1:0];

    // Operand selection and one partial product.
    always_comb begin
        case (chan)
            2'd0:    a_sel = sum_r;
            2'd1:    a_sel = sum_g;
            default: a_sel = sum_b;
        endcase
        a_half = part[1] ? a_sel[SUM_W-1:HALF_W] : a_sel[HALF_W-1:0];
        b_half = part[0] ? scale[SCALE_W-1:HALF_W] : scale[HALF_W-1:0];
        pp     = a_half * b_half;
        case (part)
            2'd0:    pp_shifted = ACC_W'(pp);
            2'd3:    pp_shifted = ACC_W'(pp) << (2 * HALF_W);
            default: pp_shifted = ACC_W'(pp) << HALF_W;
        endcase
        // The rounding constant seeds each channel's accumulation.
        acc_base = (part == 2'd0) ? (ACC_W'(1) << 31) : acc_reg;
        acc_next = acc_base + pp_shifted;
        res_next = (acc_next[ACC_W-1:80] != '0) ? SUM_MAX : acc_next[79:32];
    end

    // Step sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 4'd11) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulator and per-channel results.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            acc_reg <= acc_next;
            if (part == 2'd3) begin
                case (chan)
                    2'd0:    irr_r_reg <= res_next;
                    2'd1:    irr_g_reg <= res_next;
                    default: irr_b_reg <= res_next;
                endcase
            end
        end
    end

    assign done  = done_reg;
    assign irr_r = irr_r_reg;
    assign irr_g = irr_g_reg;
    assign irr_b = irr_b_reg;

endmodule

`default_nettype wire

@@ rtl/shda_checker.sv @@
// Port-level checker for the spatial hash density accumulator, bound to the top level.
// Depends on shda_pkg for widths and status codes.
`default_nettype none

module shda_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [shda_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire [1:0]                      m_tuser
);
    import shda_pkg::*;

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A dropped deposit reports no irradiance and no photons.
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DROPPED |-> m_tdata[175:0] == '0)
        else $error("dropped deposit carries data");

    // Only one request is in flight: the block is busy right after an accept.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

endmodule

bind spatial_hash_density_accumulator shda_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
